### hw/rtl/prrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prrs_pkg: shared types and constants for the process scheduler
// Slot entry layout, ready queue control/status words, register and
// function codes used across the scheduler modules.
// ----------------------------------------------------------------------------
package prrs_pkg;

  localparam int MAX_PROCS = 8;
  localparam int SLOT_W    = 3;
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);
  localparam int PRIO_W    = 8;
  localparam int BURST_W   = 8;
  localparam int SLICE_W   = 8;
  localparam int TICK_W    = 16;
  localparam int AGE_W     = 4;

  // configuration register indexes
  localparam logic CFG_MODE  = 1'b0;
  localparam logic CFG_AGING = 1'b1;

  // input function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // scheduling modes
  localparam logic MODE_PRIO = 1'b0;
  localparam logic MODE_RR   = 1'b1;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef struct packed {
    logic signed [PRIO_W-1:0] prio;
    logic [BURST_W-1:0]       remaining;
    logic [SLICE_W-1:0]       slice_used;
  } slot_ent_t;

  typedef struct packed {
    logic  push;
    slot_t push_slot;
    logic  pop;
  } fifo_ctl_t;

  typedef struct packed {
    logic  empty;
    logic  last;
    slot_t head_slot;
  } fifo_sts_t;

endpackage

### hw/rtl/priority_and_round_robin_scheduler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_and_round_robin_scheduler_top: process scheduler, two modes
// Priority scheduling with aging, or round robin with per-process slice.
// ----------------------------------------------------------------------------
// Usage:
//  - Command channel: drive start with in_func/in_slot/in_prio_value/in_burst;
//    a word is taken on a clock edge with start high and busy low.
//  - A load word (in_func = 0) is absorbed with busy staying low, and
//    no result word is produced.
//  - A tick word (in_func = 1) yields exactly one result word, shown for one
//    cycle with out_valid high. The receiver cannot stall it.
//  - Priority mode: a tick scans all MAX_PROCS slots through the slot memory
//    read port, one per cycle, then ages the winner, writes it back and
//    registers the result word; busy stays high through the write back.
//  - Round robin mode: running the current slot reads its slot entry, then runs
//    the tick and strobes the result; a dispatch before it pops ready-queue
//    entries, each with a queue memory read, then a check (at most MAX_PROCS).
//  - Config channel: cfg_valid/cfg_ready, cfg_index 0 = mode, 1 = aging step.
//    Always ready; write only while the block is idle.
//  - Reset (rst_n low, synchronous): mode priority, aging step 3, queue empty,
//    no slot loaded, tick counter zero, current slot 0, dispatch pending.
// ----------------------------------------------------------------------------
module priority_and_round_robin_scheduler_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // command channel
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_func,
  input  logic [prrs_pkg::SLOT_W-1:0]         in_slot,
  input  logic signed [prrs_pkg::PRIO_W-1:0]  in_prio_value,
  input  logic [prrs_pkg::BURST_W-1:0]        in_burst,
  // result channel
  output logic                                out_valid,
  output logic [prrs_pkg::SLOT_W-1:0]         out_ran_slot,
  output logic                                out_idle,
  output logic                                out_finished_now,
  output logic                                out_preempted,
  output logic                                out_all_done,
  output logic [prrs_pkg::TICK_W-1:0]         out_ticks_used,
  // configuration channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_index,
  input  logic [prrs_pkg::AGE_W-1:0]          cfg_data
);
  import prrs_pkg::*;

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;  // take commands, handle loads
  localparam logic [2:0] ST_SCAN  = 3'd1;  // priority: sweep slot memory
  localparam logic [2:0] ST_PEXEC = 3'd2;  // priority: age and write back
  localparam logic [2:0] ST_DRD   = 3'd3;  // rr: wait for queue head read
  localparam logic [2:0] ST_DCHK  = 3'd4;  // rr: pop head, dispatch or drop
  localparam logic [2:0] ST_RRD   = 3'd5;  // rr: read current slot entry
  localparam logic [2:0] ST_REXEC = 3'd6;  // rr: run one tick, write back

  logic [2:0]           state_r, state_nxt;
  logic                 mode_r;
  logic [AGE_W-1:0]     aging_r;
  // one bit per slot: loaded with burst left (remaining != 0 implies loaded)
  logic [MAX_PROCS-1:0] pending_r, pending_nxt;
  slot_t                cur_r, cur_nxt;
  logic                 need_r, need_nxt;
  logic                 fresh_r, fresh_nxt;
  logic [TICK_W-1:0]    tick_r, tick_nxt, tick_inc;

  // scan bookkeeping
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  slot_t                cmp_slot_r, cmp_slot_nxt;
  logic                 best_vld_r, best_vld_nxt;
  slot_t                best_slot_r, best_slot_nxt;
  slot_ent_t            best_ent_r, best_ent_nxt;

  // result register
  logic                 out_valid_r, out_valid_nxt;
  slot_t                out_ran_r, out_ran_nxt;
  logic                 out_idle_r, out_idle_nxt;
  logic                 out_fin_r, out_fin_nxt;
  logic                 out_pre_r, out_pre_nxt;
  logic                 out_done_r, out_done_nxt;
  logic [TICK_W-1:0]    out_ticks_r, out_ticks_nxt;

  // memory and queue hookup
  logic                 mem_we;
  slot_t                mem_waddr;
  slot_ent_t            mem_wdata;
  slot_t                mem_raddr;
  slot_ent_t            mem_rd;
  fifo_ctl_t            fifo_ctl;
  fifo_sts_t            fifo_sts;

  // tick arithmetic
  logic signed [PRIO_W:0] aged;
  logic [PRIO_W-1:0]      prio_aged;
  logic [BURST_W-1:0]     p_rem;
  logic [SLICE_W-1:0]     p_slice;
  logic [SLICE_W-1:0]     r_slice_cur;
  logic [SLICE_W:0]       r_used_next;
  logic [BURST_W-1:0]     r_rem;
  logic [SLICE_W-1:0]     r_slice;
  logic                   r_fin;
  logic                   r_pre;
  logic                   take_best;

  prrs_slot_mem u_slot_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rd)
  );

  prrs_ready_fifo u_ready_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (fifo_ctl),
    .sts   (fifo_sts)
  );

  // Priority mode: drop the winner's priority by the aging step, clamp at the
  // most negative value; burn one unit of burst; saturate the slice count.
  assign aged      = {best_ent_r.prio[PRIO_W-1], best_ent_r.prio} -
                     $signed({{(PRIO_W + 1 - AGE_W){1'b0}}, aging_r});
  assign prio_aged = (aged[PRIO_W] && !aged[PRIO_W-1]) ?
                     {1'b1, {(PRIO_W - 1){1'b0}}} : aged[PRIO_W-1:0];
  assign p_rem     = best_ent_r.remaining - 1'b1;
  assign p_slice   = (&best_ent_r.slice_used) ? best_ent_r.slice_used :
                     best_ent_r.slice_used + 1'b1;

  // Round robin: a freshly dispatched slot starts its slice from zero. The
  // slice expires when the priority equals the incremented count, so a
  // nonpositive priority never expires.
  assign r_slice_cur = fresh_r ? '0 : mem_rd.slice_used;
  assign r_used_next = {1'b0, r_slice_cur} + 1'b1;
  assign r_rem       = mem_rd.remaining - 1'b1;
  assign r_slice     = (&r_slice_cur) ? r_slice_cur : r_slice_cur + 1'b1;
  assign r_fin       = (r_rem == '0);
  assign r_pre       = !r_fin && !mem_rd.prio[PRIO_W-1] &&
                       ({1'b0, mem_rd.prio} == r_used_next);

  assign tick_inc = (&tick_r) ? tick_r : tick_r + 1'b1;

  // strict greater-than keeps the lowest slot on ties
  assign take_best = (idx_r != '0) && pending_r[cmp_slot_r] &&
                     (!best_vld_r || (mem_rd.prio > best_ent_r.prio));

  always_comb begin
    state_nxt     = state_r;
    pending_nxt   = pending_r;
    cur_nxt       = cur_r;
    need_nxt      = need_r;
    fresh_nxt     = fresh_r;
    tick_nxt      = tick_r;
    idx_nxt       = idx_r;
    cmp_slot_nxt  = cmp_slot_r;
    best_vld_nxt  = best_vld_r;
    best_slot_nxt = best_slot_r;
    best_ent_nxt  = best_ent_r;
    out_valid_nxt = 1'b0;
    out_ran_nxt   = out_ran_r;
    out_idle_nxt  = out_idle_r;
    out_fin_nxt   = out_fin_r;
    out_pre_nxt   = out_pre_r;
    mem_we        = 1'b0;
    mem_waddr     = in_slot;
    mem_wdata     = '{prio: in_prio_value, remaining: in_burst, slice_used: '0};
    mem_raddr     = cur_r;
    fifo_ctl      = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_func == FUNC_LOAD) begin
            // rewrite slot, clear slice, queue it if burst left and not running
            mem_we = 1'b1;
            pending_nxt[in_slot] = (in_burst != '0);
            if ((in_burst != '0) &&
                !(mode_r == MODE_RR && !need_r && cur_r == in_slot)) begin
              fifo_ctl.push      = 1'b1;
              fifo_ctl.push_slot = in_slot;
            end
          end else if (mode_r == MODE_PRIO) begin
            idx_nxt      = '0;
            best_vld_nxt = 1'b0;
            state_nxt    = ST_SCAN;
          end else if (!need_r && pending_r[cur_r]) begin
            fresh_nxt = 1'b0;
            state_nxt = ST_RRD;
          end else begin
            // current slot is done or none is running: dispatch
            need_nxt = 1'b1;
            if (fifo_sts.empty) begin
              out_valid_nxt = 1'b1;
              out_ran_nxt   = '0;
              out_idle_nxt  = 1'b1;
              out_fin_nxt   = 1'b0;
              out_pre_nxt   = 1'b0;
            end else begin
              state_nxt = ST_DRD;
            end
          end
        end
      end

      ST_SCAN: begin
        // issue read of slot idx, compare the entry read last cycle
        mem_raddr    = idx_r[SLOT_W-1:0];
        cmp_slot_nxt = idx_r[SLOT_W-1:0];
        idx_nxt      = idx_r + 1'b1;
        if (take_best) begin
          best_vld_nxt  = 1'b1;
          best_slot_nxt = cmp_slot_r;
          best_ent_nxt  = mem_rd;
        end
        if (idx_r == CNT_W'(MAX_PROCS)) begin
          state_nxt = ST_PEXEC;
        end
      end

      ST_PEXEC: begin
        out_valid_nxt = 1'b1;
        out_pre_nxt   = 1'b0;
        if (best_vld_r) begin
          mem_we      = 1'b1;
          mem_waddr   = best_slot_r;
          mem_wdata   = '{prio: prio_aged, remaining: p_rem, slice_used: p_slice};
          pending_nxt[best_slot_r] = (p_rem != '0);
          tick_nxt     = tick_inc;
          out_ran_nxt  = best_slot_r;
          out_idle_nxt = 1'b0;
          out_fin_nxt  = (p_rem == '0);
        end else begin
          out_ran_nxt  = '0;
          out_idle_nxt = 1'b1;
          out_fin_nxt  = 1'b0;
        end
        state_nxt = ST_IDLE;
      end

      ST_DRD: begin
        state_nxt = ST_DCHK;
      end

      ST_DCHK: begin
        // pop the head; dispatch it if it has burst left, else drop it
        fifo_ctl.pop = 1'b1;
        if (pending_r[fifo_sts.head_slot]) begin
          cur_nxt   = fifo_sts.head_slot;
          need_nxt  = 1'b0;
          fresh_nxt = 1'b1;
          state_nxt = ST_RRD;
        end else if (fifo_sts.last) begin
          out_valid_nxt = 1'b1;
          out_ran_nxt   = '0;
          out_idle_nxt  = 1'b1;
          out_fin_nxt   = 1'b0;
          out_pre_nxt   = 1'b0;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_DRD;
        end
      end

      ST_RRD: begin
        state_nxt = ST_REXEC;
      end

      ST_REXEC: begin
        mem_we    = 1'b1;
        mem_waddr = cur_r;
        mem_wdata = '{prio: mem_rd.prio, remaining: r_rem, slice_used: r_slice};
        pending_nxt[cur_r] = !r_fin;
        if (r_fin || r_pre) begin
          need_nxt = 1'b1;
        end
        if (r_pre) begin
          fifo_ctl.push      = 1'b1;
          fifo_ctl.push_slot = cur_r;
        end
        tick_nxt      = tick_inc;
        out_valid_nxt = 1'b1;
        out_ran_nxt   = cur_r;
        out_idle_nxt  = 1'b0;
        out_fin_nxt   = r_fin;
        out_pre_nxt   = r_pre;
        state_nxt     = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // status is taken after the tick's updates
    out_done_nxt  = ~|pending_nxt;
    out_ticks_nxt = tick_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_PRIO;
      aging_r     <= AGE_W'(3);
      pending_r   <= '0;
      cur_r       <= '0;
      need_r      <= 1'b1;
      fresh_r     <= 1'b0;
      tick_r      <= '0;
      idx_r       <= '0;
      best_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pending_r   <= pending_nxt;
      cur_r       <= cur_nxt;
      need_r      <= need_nxt;
      fresh_r     <= fresh_nxt;
      tick_r      <= tick_nxt;
      idx_r       <= idx_nxt;
      best_vld_r  <= best_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MODE:  mode_r  <= cfg_data[0];
          CFG_AGING: aging_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    cmp_slot_r  <= cmp_slot_nxt;
    best_slot_r <= best_slot_nxt;
    best_ent_r  <= best_ent_nxt;
    out_ran_r   <= out_ran_nxt;
    out_idle_r  <= out_idle_nxt;
    out_fin_r   <= out_fin_nxt;
    out_pre_r   <= out_pre_nxt;
    out_done_r  <= out_done_nxt;
    out_ticks_r <= out_ticks_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_ran_slot     = out_ran_r;
  assign out_idle         = out_idle_r;
  assign out_finished_now = out_fin_r;
  assign out_preempted    = out_pre_r;
  assign out_all_done     = out_done_r;
  assign out_ticks_used   = out_ticks_r;

endmodule

### hw/rtl/prrs_slot_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prrs_slot_mem: per-slot state memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module prrs_slot_mem (
  input  logic               clk,
  input  logic               wr_en,
  input  prrs_pkg::slot_t    wr_addr,
  input  prrs_pkg::slot_ent_t wr_data,
  input  prrs_pkg::slot_t    rd_addr,
  output prrs_pkg::slot_ent_t rd_data
);
  import prrs_pkg::*;

  slot_ent_t mem [MAX_PROCS];
  slot_ent_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/prrs_ready_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prrs_ready_fifo: round-robin ready queue
// Circular queue of slot numbers in a small memory, with a queued flag per
// slot so that a slot is never held twice. Head read data is registered.
// ----------------------------------------------------------------------------
module prrs_ready_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  prrs_pkg::fifo_ctl_t ctl,
  output prrs_pkg::fifo_sts_t sts
);
  import prrs_pkg::*;

  slot_t                mem [MAX_PROCS];
  slot_t                rd_data_r;
  slot_t                head_r, head_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [MAX_PROCS-1:0] queued_r, queued_nxt;
  logic [SLOT_W:0]      tail_sum;
  slot_t                tail;
  logic                 do_push;

  assign do_push  = ctl.push && !queued_r[ctl.push_slot];
  assign tail_sum = {1'b0, head_r} + (SLOT_W + 1)'(count_r);
  assign tail     = (tail_sum >= (SLOT_W + 1)'(MAX_PROCS)) ?
                    SLOT_W'(tail_sum - (SLOT_W + 1)'(MAX_PROCS)) : tail_sum[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[tail] <= ctl.push_slot;
    end
    rd_data_r <= mem[head_r];
  end

  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    queued_nxt = queued_r;
    if (ctl.pop) begin
      head_nxt  = (head_r == SLOT_W'(MAX_PROCS - 1)) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
      queued_nxt[rd_data_r] = 1'b0;
    end else if (do_push) begin
      count_nxt = count_r + 1'b1;
      queued_nxt[ctl.push_slot] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      count_r  <= '0;
      queued_r <= '0;
    end else begin
      head_r   <= head_nxt;
      count_r  <= count_nxt;
      queued_r <= queued_nxt;
    end
  end

  assign sts.empty     = (count_r == '0);
  assign sts.last      = (count_r == CNT_W'(1));
  assign sts.head_slot = rd_data_r;

endmodule

### tb/sv/prrs_sched_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prrs_sched_check_pkg: tick result predictor and checker for the scheduler
// Mirrors the slot table, ready queue and dispatch state of the scheduler,
// predicts the result word of every accepted tick and compares it with the
// word that the block returns.
// ----------------------------------------------------------------------------
package prrs_sched_check_pkg;

  import prrs_pkg::*;

  typedef struct {
    slot_t             ran_slot;
    logic              idle;
    logic              finished_now;
    logic              preempted;
    logic              all_done;
    logic [TICK_W-1:0] ticks_used;
  } tick_result_t;

  class sched_result_board;

    logic                     mode;
    logic [AGE_W-1:0]         aging_step;
    logic signed [PRIO_W-1:0] sl_prio   [MAX_PROCS];
    logic [BURST_W-1:0]       sl_left   [MAX_PROCS];
    logic [SLICE_W-1:0]       sl_slice  [MAX_PROCS];
    bit                       sl_loaded [MAX_PROCS];
    slot_t                    run_queue [$];
    slot_t                    run_slot;
    bit                       redispatch;
    logic [TICK_W-1:0]        tick_total;
    tick_result_t             pending_results [$];
    int                       mismatches;
    int                       printed;

    function new();
      mode       = MODE_PRIO;
      aging_step = 4'd3;
      for (int i = 0; i < MAX_PROCS; i++) begin
        sl_prio[i]   = '0;
        sl_left[i]   = '0;
        sl_slice[i]  = '0;
        sl_loaded[i] = 1'b0;
      end
      run_slot    = '0;
      redispatch  = 1'b1;
      tick_total  = '0;
      mismatches  = 0;
      printed     = 0;
    endfunction

    function void note_config(logic index, logic [AGE_W-1:0] data);
      if (index == CFG_MODE) begin
        mode = data[0];
      end else begin
        aging_step = data;
      end
    endfunction

    // append unless already queued or the queue is full
    function void enqueue_ready(slot_t s);
      if (run_queue.size() >= MAX_PROCS) return;
      foreach (run_queue[i]) begin
        if (run_queue[i] == s) return;
      end
      run_queue.push_back(s);
    endfunction

    function bit all_finished();
      for (int i = 0; i < MAX_PROCS; i++) begin
        if (sl_loaded[i] && sl_left[i] != 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_word(logic func, slot_t slot, logic signed [PRIO_W-1:0] prio,
                            logic [BURST_W-1:0] burst);
      tick_result_t r;
      int           best;
      int           aged;
      int           used_next;
      slot_t        c;
      slot_t        h;
      bit           ran;
      if (func == FUNC_LOAD) begin
        sl_prio[slot]   = prio;
        sl_left[slot]   = burst;
        sl_slice[slot]  = '0;
        sl_loaded[slot] = 1'b1;
        if (burst != 0 && !(mode == MODE_RR && !redispatch && run_slot == slot))
          enqueue_ready(slot);
        return;
      end
      ran            = 1'b0;
      c              = '0;
      r.finished_now = 1'b0;
      r.preempted    = 1'b0;
      if (mode == MODE_PRIO) begin
        best = -1;
        for (int i = 0; i < MAX_PROCS; i++) begin
          if (sl_loaded[i] && sl_left[i] != 0 && (best < 0 || sl_prio[i] > sl_prio[best]))
            best = i;
        end
        if (best >= 0) begin
          aged = int'(sl_prio[best]) - int'(aging_step);
          if (aged < -128) aged = -128;
          sl_prio[best] = aged[7:0];
          sl_left[best] = sl_left[best] - 1'b1;
          if (sl_slice[best] != '1) sl_slice[best] = sl_slice[best] + 1'b1;
          r.finished_now = (sl_left[best] == 0);
          c   = slot_t'(best);
          ran = 1'b1;
        end
      end else begin
        if (!redispatch && sl_left[run_slot] == 0) redispatch = 1'b1;
        // pop until a slot with work left turns up, drop finished ones
        while (redispatch && run_queue.size() > 0) begin
          h = run_queue.pop_front();
          if (sl_left[h] != 0) begin
            run_slot    = h;
            sl_slice[h] = '0;
            redispatch  = 1'b0;
          end
        end
        if (!redispatch) begin
          c         = run_slot;
          used_next = int'(sl_slice[c]) + 1;
          sl_left[c] = sl_left[c] - 1'b1;
          if (sl_slice[c] != '1) sl_slice[c] = sl_slice[c] + 1'b1;
          if (sl_left[c] == 0) begin
            r.finished_now = 1'b1;
            redispatch     = 1'b1;
          end else if (int'(sl_prio[c]) == used_next) begin
            r.preempted = 1'b1;
            redispatch  = 1'b1;
            enqueue_ready(c);
          end
          ran = 1'b1;
        end
      end
      if (ran && tick_total != '1) tick_total = tick_total + 1'b1;
      r.ran_slot   = ran ? c : '0;
      r.idle       = !ran;
      r.all_done   = all_finished();
      r.ticks_used = tick_total;
      pending_results.push_back(r);
    endfunction

    task report_mismatch(string what, int got, int want);
      mismatches++;
      if (printed < 20) begin
        printed++;
        $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
      end
    endtask

    task check_result(tick_result_t got);
      tick_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("result word with no tick waiting", 1, 0);
        return;
      end
      want = pending_results.pop_front();
      if (got.ran_slot !== want.ran_slot)
        report_mismatch("ran_slot", int'(got.ran_slot), int'(want.ran_slot));
      if (got.idle !== want.idle)
        report_mismatch("idle", int'(got.idle), int'(want.idle));
      if (got.finished_now !== want.finished_now)
        report_mismatch("finished_now", int'(got.finished_now), int'(want.finished_now));
      if (got.preempted !== want.preempted)
        report_mismatch("preempted", int'(got.preempted), int'(want.preempted));
      if (got.all_done !== want.all_done)
        report_mismatch("all_done", int'(got.all_done), int'(want.all_done));
      if (got.ticks_used !== want.ticks_used)
        report_mismatch("ticks_used", int'(got.ticks_used), int'(want.ticks_used));
    endtask

    function int pending();
      return pending_results.size();
    endfunction

  endclass

endpackage

### tb/sv/priority_and_round_robin_scheduler_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_and_round_robin_scheduler_top_test: scheduler self-checking bench
// Drives load and tick words into the scheduler, first a directed walk through
// both modes and their corner cases, then random segments under changing mode
// and aging settings and changing sender gaps. Every tick result word is
// checked field by field against a predicted one.
// ----------------------------------------------------------------------------
module priority_and_round_robin_scheduler_top_test;

  import prrs_pkg::*;
  import prrs_sched_check_pkg::*;

  // settle time after the last result: longer than the longest round robin
  // dispatch, which pops every ready-queue entry
  localparam int SETTLE_CYCLES = 24;
  // bound for about 1950 words plus sender gaps, set well above the expected
  // length of the run
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SEG_COUNT     = 12;
  localparam int SEG_WORDS     = 160;

  localparam logic signed [PRIO_W-1:0] PRIO_MIN = PRIO_W'(-128);
  localparam logic signed [PRIO_W-1:0] PRIO_MAX = PRIO_W'(127);

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic                     in_func;
  slot_t                    in_slot;
  logic signed [PRIO_W-1:0] in_prio_value;
  logic [BURST_W-1:0]       in_burst;
  logic                     out_valid;
  slot_t                    out_ran_slot;
  logic                     out_idle;
  logic                     out_finished_now;
  logic                     out_preempted;
  logic                     out_all_done;
  logic [TICK_W-1:0]        out_ticks_used;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic                     cfg_index;
  logic [AGE_W-1:0]         cfg_data;

  sched_result_board board = new();
  tick_result_t      seen_result;
  int                cycle_count = 0;

  priority_and_round_robin_scheduler_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_slot          (in_slot),
    .in_prio_value    (in_prio_value),
    .in_burst         (in_burst),
    .out_valid        (out_valid),
    .out_ran_slot     (out_ran_slot),
    .out_idle         (out_idle),
    .out_finished_now (out_finished_now),
    .out_preempted    (out_preempted),
    .out_all_done     (out_all_done),
    .out_ticks_used   (out_ticks_used),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // hard stop in case a handshake never completes
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result words last one cycle and cannot be held off: grab each one here
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      seen_result.ran_slot     = out_ran_slot;
      seen_result.idle         = out_idle;
      seen_result.finished_now = out_finished_now;
      seen_result.preempted    = out_preempted;
      seen_result.all_done     = out_all_done;
      seen_result.ticks_used   = out_ticks_used;
      board.check_result(seen_result);
    end
  end

  // Present one command word from the falling edge and hold it until the
  // block takes it. Start is left high on return: the caller either drives
  // the next word or drops start at the next falling edge, never both.
  task automatic send_word(logic func, slot_t slot, logic signed [PRIO_W-1:0] prio,
                           logic [BURST_W-1:0] burst);
    @(negedge clk);
    start         <= 1'b1;
    in_func       <= func;
    in_slot       <= slot;
    in_prio_value <= prio;
    in_burst      <= burst;
    do @(posedge clk); while (busy !== 1'b0);
    board.note_word(func, slot, prio, burst);
  endtask

  // Write one register; only called with the block drained and settled.
  task automatic write_reg(logic index, logic [AGE_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    board.note_config(index, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Hold the sender off until every predicted result word is back, then let
  // the block finish any dispatch it may still be walking through.
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random words: somewhat more ticks than loads; loads mostly with short bursts
  // and small priorities so that round robin slices expire often; extremes mixed in.
  task automatic send_random_words(int count, int idle_pct);
    logic                     func;
    slot_t                    slot;
    logic signed [PRIO_W-1:0] prio;
    logic [BURST_W-1:0]       burst;
    for (int n = 0; n < count; n++) begin
      while ($urandom_range(99) < idle_pct) begin
        @(negedge clk);
        start <= 1'b0;
      end
      func = ($urandom_range(99) < 55) ? FUNC_TICK : FUNC_LOAD;
      slot = slot_t'($urandom_range(MAX_PROCS - 1));
      case ($urandom_range(7))
        0, 1, 2: prio = PRIO_W'($urandom_range(4, 1));
        3:       prio = PRIO_W'($urandom_range(255));
        4:       prio = PRIO_MIN;
        5:       prio = PRIO_MAX;
        6: begin
          // zero or negative: slice never runs out
          prio = PRIO_W'($urandom_range(3));
          prio = -prio;
        end
        default: prio = PRIO_W'($urandom_range(12, 5));
      endcase
      case ($urandom_range(9))
        0:       burst = '0;
        1:       burst = BURST_W'($urandom_range(255));
        default: burst = BURST_W'($urandom_range(6, 1));
      endcase
      send_word(func, slot, prio, burst);
    end
  endtask

  initial begin
    logic [AGE_W-1:0] aging_pick;
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_func       <= FUNC_LOAD;
    in_slot       <= '0;
    in_prio_value <= '0;
    in_burst      <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= CFG_MODE;
    cfg_data      <= '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Priority mode, reset aging step.
    // Tick with nothing loaded: idle, all done holds vacuously.
    send_word(FUNC_TICK, 3'd0, 8'sd0, 8'd0);
    send_word(FUNC_LOAD, 3'd7, PRIO_MIN, 8'd2);
    send_word(FUNC_LOAD, 3'd0, PRIO_MAX, 8'd1);
    // zero burst: loaded and already finished, never queued
    send_word(FUNC_LOAD, 3'd3, 8'sd5, 8'd0);
    // slot 0 wins and finishes, then slot 7 runs with aging pinned at the floor
    send_word(FUNC_TICK, 3'd7, PRIO_MAX, 8'hff);
    send_word(FUNC_TICK, 3'd0, PRIO_MIN, 8'd0);
    // reload a slot that sits in the ready queue: no second entry
    send_word(FUNC_LOAD, 3'd7, PRIO_MIN, 8'hff);
    send_word(FUNC_TICK, 3'd0, 8'sd0, 8'd0);
    drain_results();

    // Round robin over the same slot state. Queue holds 7 then finished 0.
    write_reg(CFG_MODE, AGE_W'(MODE_RR));
    send_word(FUNC_LOAD, 3'd2, 8'sd2, 8'd3);
    send_word(FUNC_LOAD, 3'd5, 8'sd0, 8'd3);
    // slot 7 dispatched; with a negative priority its slice never expires
    send_word(FUNC_TICK, 3'd0, 8'sd0, 8'd0);
    // reload the running slot with zero burst: forces a fresh dispatch
    send_word(FUNC_LOAD, 3'd7, 8'sd1, 8'd0);
    // finished slot 0 dropped at dispatch, slot 2 runs then is preempted
    send_word(FUNC_TICK, 3'd0, 8'sd0, 8'd0);
    send_word(FUNC_TICK, 3'd0, 8'sd0, 8'd0);
    // slot 5 runs to completion, slot 2 comes back and finishes, then idle
    repeat (5) send_word(FUNC_TICK, 3'd0, 8'sd0, 8'd0);
    drain_results();

    // Random segments. Sender gaps: 28 percent, then 71 percent, then none.
    // Every segment starts from a drained block with new register settings.
    for (int seg = 0; seg < SEG_COUNT; seg++) begin
      case (seg % 3)
        0:       aging_pick = '0;
        1:       aging_pick = '1;
        default: aging_pick = AGE_W'($urandom_range(15));
      endcase
      write_reg(CFG_MODE, AGE_W'((seg % 2 == 1) ? MODE_RR : MODE_PRIO));
      write_reg(CFG_AGING, aging_pick);
      send_random_words(SEG_WORDS, (seg < 4) ? 28 : (seg < 8) ? 71 : 0);
      drain_results();
    end

    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/prrs_pkg.sv
hw/rtl/prrs_slot_mem.sv
hw/rtl/prrs_ready_fifo.sv
hw/rtl/priority_and_round_robin_scheduler_top.sv
tb/sv/prrs_sched_check_pkg.sv
tb/sv/priority_and_round_robin_scheduler_top_test.sv
